// ===== src/ips_pkg.sv =====
package ips_pkg;

	// pixel and field widths
	localparam int PIX_W      = 24;
	localparam int CHAN_W     = 8;
	localparam int PAD_W      = 2;
	localparam int CFG_IDX_W  = 2;
	localparam int CFG_DATA_W = 11;
	localparam int FACTOR_W   = 5;
	localparam int WIDTH_W    = 11;

	// input opcodes
	localparam logic OP_PIXEL  = 1'b0;
	localparam logic OP_REPLAY = 1'b1;

	// scale modes
	localparam logic MODE_REPLICATE = 1'b0;
	localparam logic MODE_DECIMATE  = 1'b1;

	// configuration register indexes
	localparam logic [CFG_IDX_W-1:0] CFG_MODE   = 2'd0;
	localparam logic [CFG_IDX_W-1:0] CFG_FACTOR = 2'd1;
	localparam logic [CFG_IDX_W-1:0] CFG_WIDTH  = 2'd2;

	// status of the config divider
	typedef struct packed {
		logic       busy;
		logic       done;
		logic [1:0] quo_lsb;
	} ips_div_stat_t;

endpackage

// ===== src/ips_ram.sv =====
module ips_ram #(
	parameter int WIDTH = 24,
	parameter int DEPTH = 1024
) (
	input  logic                                    clk,
	input  logic                                    wr_en,
	input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] wr_addr,
	input  logic [WIDTH-1:0]                        wr_data,
	input  logic                                    rd_en,
	input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] rd_addr,
	output logic [WIDTH-1:0]                        rd_data
);

	logic [WIDTH-1:0] mem_q [DEPTH];

	// one write port, one registered read port
	always_ff @(posedge clk) begin
		if (wr_en) begin
			mem_q[wr_addr] <= wr_data;
		end
		if (rd_en) begin
			rd_data <= mem_q[rd_addr];
		end
	end

endmodule

// ===== src/ips_div.sv =====
module ips_div #(
	parameter int DW  = 12,
	parameter int FCW = 5,
	parameter int FW  = 4
) (
	input  logic                    clk,
	input  logic                    arst_n,
	input  logic                    start,
	input  logic [DW-1:0]           dividend_a,
	input  logic [DW-1:0]           dividend_b,
	input  logic [FCW-1:0]          divisor,
	output ips_pkg::ips_div_stat_t  stat,
	output logic [FW-1:0]           rem_b
);

	localparam int SW = $clog2(DW + 1);

	logic          busy_q;
	logic          done_q;
	logic [SW-1:0] cnt_q;
	logic [DW-1:0] a_q;
	logic [DW-1:0] b_q;
	logic [FCW-1:0] d_q;
	logic [FCW-1:0] ra_q;
	logic [FCW-1:0] rb_q;
	logic [1:0]    q_q;

	logic [FCW:0]   ta;
	logic [FCW:0]   tb;
	logic           ge_a;
	logic           ge_b;
	logic [FCW-1:0] ra_nx;
	logic [FCW-1:0] rb_nx;

	// one restoring step on both dividends
	always_comb begin
		ta    = {ra_q, a_q[DW-1]};
		tb    = {rb_q, b_q[DW-1]};
		ge_a  = ta >= {1'b0, d_q};
		ge_b  = tb >= {1'b0, d_q};
		ra_nx = ge_a ? FCW'(ta - {1'b0, d_q}) : FCW'(ta);
		rb_nx = ge_b ? FCW'(tb - {1'b0, d_q}) : FCW'(tb);
	end

	// step control
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			cnt_q  <= '0;
		end else if (start) begin
			busy_q <= 1'b1;
			done_q <= 1'b0;
			cnt_q  <= SW'(DW);
		end else if (busy_q) begin
			cnt_q <= cnt_q - SW'(1);
			if (cnt_q == SW'(1)) begin
				busy_q <= 1'b0;
				done_q <= 1'b1;
			end
		end else begin
			done_q <= 1'b0;
		end
	end

	// operand and partial remainder registers
	always_ff @(posedge clk) begin
		if (start) begin
			a_q  <= dividend_a;
			b_q  <= dividend_b;
			d_q  <= divisor;
			ra_q <= '0;
			rb_q <= '0;
			q_q  <= '0;
		end else if (busy_q) begin
			a_q  <= {a_q[DW-2:0], 1'b0};
			b_q  <= {b_q[DW-2:0], 1'b0};
			ra_q <= ra_nx;
			rb_q <= rb_nx;
			q_q  <= {q_q[0], ge_a};
		end
	end

	assign stat.busy    = busy_q;
	assign stat.done    = done_q;
	assign stat.quo_lsb = q_q;
	assign rem_b        = FW'(rb_q);

endmodule

// ===== src/integer_pixel_scaler_top.sv =====
// channel  direction  handshake             payload
// in       to block   in_valid / in_stall   opcode, red, green, blue
// out      from block out_valid / out_stall red_out .. blue_out, has_pixel, pad_bytes,
//                                           rejected, last
// cfg      to block   cfg_valid / cfg_ready cfg_index, cfg_data
//
// An item is decided in the cycle it is accepted; its results leave one per cycle, while the
// output is not stalled, from the emit stage through the output register, so a new pixel or
// replay gives scale_factor results and the next item follows the last one. Dropped pixels
// give no result; padding and rejected items give one. After reset the block is ready at once.
// Each config write stalls input while output width and column phase are recomputed by a
// one-bit-per-cycle divider: the kick register, one divider step per dividend bit (11 at the
// default sizes) and the done flag.
module integer_pixel_scaler_top #(
	parameter int MAX_WIDTH  = 1024,
	parameter int MAX_FACTOR = 16
) (
	input  logic                             clk,
	input  logic                             arst_n,
	// input channel
	input  logic                             in_valid,
	output logic                             in_stall,
	input  logic                             opcode,
	input  logic [ips_pkg::CHAN_W-1:0]       red,
	input  logic [ips_pkg::CHAN_W-1:0]       green,
	input  logic [ips_pkg::CHAN_W-1:0]       blue,
	// output channel
	output logic                             out_valid,
	input  logic                             out_stall,
	output logic [ips_pkg::CHAN_W-1:0]       red_out,
	output logic [ips_pkg::CHAN_W-1:0]       green_out,
	output logic [ips_pkg::CHAN_W-1:0]       blue_out,
	output logic                             has_pixel,
	output logic [ips_pkg::PAD_W-1:0]        pad_bytes,
	output logic                             rejected,
	output logic                             last,
	// config channel
	input  logic                             cfg_valid,
	output logic                             cfg_ready,
	input  logic [ips_pkg::CFG_IDX_W-1:0]    cfg_index,
	input  logic [ips_pkg::CFG_DATA_W-1:0]   cfg_data
);

	localparam int CW  = (MAX_WIDTH > 1) ? $clog2(MAX_WIDTH) : 1;
	localparam int WCW = $clog2(MAX_WIDTH + 1);
	localparam int FW  = (MAX_FACTOR > 1) ? $clog2(MAX_FACTOR) : 1;
	localparam int FCW = $clog2(MAX_FACTOR + 1);
	localparam int DW  = $clog2(MAX_WIDTH + MAX_FACTOR);
	localparam int PW  = ips_pkg::PIX_W;

	// config registers
	logic                          mode_q;
	logic [ips_pkg::FACTOR_W-1:0]  factor_q;
	logic [ips_pkg::WIDTH_W-1:0]   width_q;
	logic                          kick_q;

	// scaler state
	logic [CW-1:0] column_q;
	logic [FW-1:0] col_mod_q;
	logic [FW-1:0] row_phase_q;
	logic [FW-1:0] replays_q;
	logic [CW-1:0] replay_col_q;
	logic [1:0]    dec_pad_q;

	// emit stage
	logic          valid_s1;
	logic          has_s1;
	logic          rej_s1;
	logic          replay_s1;
	logic [1:0]    pad_s1;
	logic [FW-1:0] left_s1;
	logic [PW-1:0] pix_s1;

	// output register
	logic          out_valid_q;
	logic [PW-1:0] out_pix_q;
	logic          out_has_q;
	logic [1:0]    out_pad_q;
	logic          out_rej_q;
	logic          out_last_q;

	// derived
	logic [FCW-1:0] eff_f;
	logic [WCW-1:0] eff_w;
	logic [WCW-1:0] w_m1;
	logic [1:0]     rep_pad;
	logic [3:0]     rep_prod;
	logic           cfg_wr;
	logic           busy_any;
	logic           emit;
	logic           s1_done;
	logic           accept;
	logic [PW-1:0]  in_pix;
	logic [PW-1:0]  s1_pix;

	// item decode
	logic          ld;
	logic          ld_has;
	logic          ld_rej;
	logic          ld_replay;
	logic [1:0]    ld_pad;
	logic [FW-1:0] ld_left;
	logic          wr_en;
	logic          rd_en;
	logic          px_end;
	logic          rp_end;
	logic          out_row;
	logic [1:0]    dec_pad;
	logic [CW-1:0] column_nx;
	logic [FW-1:0] col_mod_nx;
	logic [FW-1:0] col_mod_inc;
	logic [FW-1:0] row_phase_nx;
	logic [FW-1:0] row_phase_inc;
	logic [FW-1:0] replays_nx;
	logic [CW-1:0] replay_col_nx;

	ips_pkg::ips_div_stat_t div_stat;
	logic [FW-1:0]          div_rem;
	logic [PW-1:0]          ram_rdata;

	// effective factor and width
	always_comb begin
		if (factor_q == '0) begin
			eff_f = FCW'(1);
		end else if (32'(factor_q) > 32'(MAX_FACTOR)) begin
			eff_f = FCW'(MAX_FACTOR);
		end else begin
			eff_f = FCW'(factor_q);
		end
		if (width_q == '0) begin
			eff_w = WCW'(1);
		end else if (32'(width_q) > 32'(MAX_WIDTH)) begin
			eff_w = WCW'(MAX_WIDTH);
		end else begin
			eff_w = WCW'(width_q);
		end
		w_m1     = eff_w - WCW'(1);
		rep_prod = {2'b00, eff_w[1:0]} * {2'b00, 2'(eff_f)};
		rep_pad  = rep_prod[1:0];
	end

	// config write
	assign cfg_ready = 1'b1;
	assign cfg_wr    = cfg_valid && cfg_ready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			mode_q   <= ips_pkg::MODE_REPLICATE;
			factor_q <= ips_pkg::FACTOR_W'(1);
			width_q  <= ips_pkg::WIDTH_W'(1);
			kick_q   <= 1'b0;
		end else begin
			kick_q <= cfg_wr;
			if (cfg_wr) begin
				case (cfg_index)
					ips_pkg::CFG_MODE:   mode_q   <= cfg_data[0];
					ips_pkg::CFG_FACTOR: factor_q <= cfg_data[ips_pkg::FACTOR_W-1:0];
					ips_pkg::CFG_WIDTH:  width_q  <= cfg_data[ips_pkg::WIDTH_W-1:0];
					default: ;
				endcase
			end
		end
	end

	// output width and column phase after a config change
	ips_div #(
		.DW  (DW),
		.FCW (FCW),
		.FW  (FW)
	) u_div (
		.clk        (clk),
		.arst_n     (arst_n),
		.start      (kick_q),
		.dividend_a (DW'(eff_w) + DW'(eff_f) - DW'(1)),
		.dividend_b (DW'(column_q)),
		.divisor    (eff_f),
		.stat       (div_stat),
		.rem_b      (div_rem)
	);

	// handshake
	assign busy_any = kick_q || div_stat.busy || div_stat.done;
	assign emit     = valid_s1 && (!out_valid_q || !out_stall);
	assign s1_done  = emit && (left_s1 == '0);
	assign in_stall = busy_any || (valid_s1 && !s1_done);
	assign accept   = in_valid && !in_stall;
	assign in_pix   = {red, green, blue};

	// decide results and next state of one item
	always_comb begin
		px_end        = WCW'(column_q) >= w_m1;
		rp_end        = WCW'(replay_col_q) >= w_m1;
		out_row       = row_phase_q == '0;
		dec_pad       = (px_end && out_row) ? dec_pad_q : 2'd0;
		col_mod_inc   = ((FCW'(col_mod_q) + FCW'(1)) >= eff_f) ? '0 : col_mod_q + FW'(1);
		row_phase_inc = ((FCW'(row_phase_q) + FCW'(1)) >= eff_f) ? '0
		                : row_phase_q + FW'(1);

		ld            = 1'b0;
		ld_has        = 1'b0;
		ld_rej        = 1'b0;
		ld_replay     = 1'b0;
		ld_pad        = 2'd0;
		ld_left       = '0;
		wr_en         = 1'b0;
		rd_en         = 1'b0;
		column_nx     = column_q;
		col_mod_nx    = col_mod_q;
		row_phase_nx  = row_phase_q;
		replays_nx    = replays_q;
		replay_col_nx = replay_col_q;

		if (opcode == ips_pkg::OP_PIXEL) begin
			if (replays_q != '0) begin
				ld     = 1'b1;
				ld_rej = 1'b1;
			end else begin
				if (px_end) begin
					column_nx  = '0;
					col_mod_nx = '0;
				end else begin
					column_nx  = column_q + CW'(1);
					col_mod_nx = col_mod_inc;
				end
				if (mode_q == ips_pkg::MODE_REPLICATE) begin
					wr_en   = 1'b1;
					ld      = 1'b1;
					ld_has  = 1'b1;
					ld_pad  = px_end ? rep_pad : 2'd0;
					ld_left = FW'(eff_f - FCW'(1));
					if (px_end) begin
						replays_nx    = FW'(eff_f - FCW'(1));
						replay_col_nx = '0;
					end
				end else begin
					if (out_row && (col_mod_q == '0)) begin
						ld     = 1'b1;
						ld_has = 1'b1;
						ld_pad = dec_pad;
					end else if (dec_pad != 2'd0) begin
						ld     = 1'b1;
						ld_pad = dec_pad;
					end
					if (px_end) begin
						row_phase_nx = row_phase_inc;
					end
				end
			end
		end else begin
			if ((mode_q != ips_pkg::MODE_REPLICATE) || (replays_q == '0)) begin
				ld     = 1'b1;
				ld_rej = 1'b1;
			end else begin
				rd_en     = 1'b1;
				ld        = 1'b1;
				ld_has    = 1'b1;
				ld_replay = 1'b1;
				ld_pad    = rp_end ? rep_pad : 2'd0;
				ld_left   = FW'(eff_f - FCW'(1));
				if (rp_end) begin
					replay_col_nx = '0;
					replays_nx    = replays_q - FW'(1);
				end else begin
					replay_col_nx = replay_col_q + CW'(1);
				end
			end
		end
	end

	// line buffer
	ips_ram #(
		.WIDTH (PW),
		.DEPTH (MAX_WIDTH)
	) u_line (
		.clk     (clk),
		.wr_en   (accept && wr_en),
		.wr_addr (column_q),
		.wr_data (in_pix),
		.rd_en   (accept && rd_en),
		.rd_addr (replay_col_q),
		.rd_data (ram_rdata)
	);

	// state registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			column_q     <= '0;
			col_mod_q    <= '0;
			row_phase_q  <= '0;
			replays_q    <= '0;
			replay_col_q <= '0;
			dec_pad_q    <= 2'd1;
		end else if (div_stat.done) begin
			dec_pad_q <= div_stat.quo_lsb;
			col_mod_q <= div_rem;
		end else if (accept) begin
			column_q     <= column_nx;
			col_mod_q    <= col_mod_nx;
			row_phase_q  <= row_phase_nx;
			replays_q    <= replays_nx;
			replay_col_q <= replay_col_nx;
		end
	end

	// emit stage and output register control
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1    <= 1'b0;
			left_s1     <= '0;
			out_valid_q <= 1'b0;
		end else begin
			if (emit) begin
				out_valid_q <= 1'b1;
			end else if (!out_stall) begin
				out_valid_q <= 1'b0;
			end
			if (emit && (left_s1 != '0)) begin
				left_s1 <= left_s1 - FW'(1);
			end
			if (accept && ld) begin
				valid_s1 <= 1'b1;
				left_s1  <= ld_left;
			end else if (s1_done) begin
				valid_s1 <= 1'b0;
			end
		end
	end

	assign s1_pix = replay_s1 ? ram_rdata : pix_s1;

	// emit stage and output register payload
	always_ff @(posedge clk) begin
		if (accept && ld) begin
			has_s1    <= ld_has;
			rej_s1    <= ld_rej;
			replay_s1 <= ld_replay;
			pad_s1    <= ld_pad;
			pix_s1    <= in_pix;
		end
		if (emit) begin
			out_pix_q  <= has_s1 ? s1_pix : '0;
			out_has_q  <= has_s1;
			out_rej_q  <= rej_s1;
			out_last_q <= left_s1 == '0;
			out_pad_q  <= (left_s1 == '0) ? pad_s1 : 2'd0;
		end
	end

	assign out_valid = out_valid_q;
	assign red_out   = out_pix_q[23:16];
	assign green_out = out_pix_q[15:8];
	assign blue_out  = out_pix_q[7:0];
	assign has_pixel = out_has_q;
	assign pad_bytes = out_pad_q;
	assign rejected  = out_rej_q;
	assign last      = out_last_q;

endmodule

// ===== tb/tb_integer_pixel_scaler_top.sv =====
module tb_integer_pixel_scaler_top;
	timeunit 1ns;
	timeprecision 1ps;

	localparam int LINE_DEPTH = 1024;
	localparam int FACTOR_CAP = 16;
	localparam int WIDTH_CAP  = 1024;
	localparam int SETTLE_CYC = 24;
	localparam int HOLD_CYC   = 300;
	localparam int PHASES     = 6;
	localparam int PHASE_LEN  = 30;
	localparam logic [ips_pkg::CFG_IDX_W-1:0] CFG_SPARE = 2'd3;

	// one output pixel transfer
	typedef struct {
		logic [ips_pkg::CHAN_W-1:0] red;
		logic [ips_pkg::CHAN_W-1:0] green;
		logic [ips_pkg::CHAN_W-1:0] blue;
		logic                       has_pixel;
		logic [ips_pkg::PAD_W-1:0]  pad_bytes;
		logic                       rejected;
		logic                       last;
	} pix_res_t;

	logic                           clk = 1'b0;
	logic                           arst_n = 1'b0;
	logic                           in_valid = 1'b0;
	logic                           in_stall;
	logic                           opcode = ips_pkg::OP_PIXEL;
	logic [ips_pkg::CHAN_W-1:0]     red = '0;
	logic [ips_pkg::CHAN_W-1:0]     green = '0;
	logic [ips_pkg::CHAN_W-1:0]     blue = '0;
	logic                           out_valid;
	logic                           out_stall = 1'b0;
	logic [ips_pkg::CHAN_W-1:0]     red_out;
	logic [ips_pkg::CHAN_W-1:0]     green_out;
	logic [ips_pkg::CHAN_W-1:0]     blue_out;
	logic                           has_pixel;
	logic [ips_pkg::PAD_W-1:0]      pad_bytes;
	logic                           rejected;
	logic                           last;
	logic                           cfg_valid = 1'b0;
	logic                           cfg_ready;
	logic [ips_pkg::CFG_IDX_W-1:0]  cfg_index = '0;
	logic [ips_pkg::CFG_DATA_W-1:0] cfg_data = '0;

	// shadow of the scaler registers and state
	logic                           reg_mode;
	logic [ips_pkg::FACTOR_W-1:0]   reg_factor;
	logic [ips_pkg::WIDTH_W-1:0]    reg_width;
	logic [ips_pkg::PIX_W-1:0]      line_mem [LINE_DEPTH];
	logic [9:0]                     col_pos;
	logic [3:0]                     row_ph;
	logic [3:0]                     rows_owed;
	logic [9:0]                     rep_pos;

	pix_res_t owed[$];
	int       errors = 0;
	bit       calm = 1'b0;
	bit       hold_req = 1'b0;
	int       hold_cnt = 0;
	int       stall_run = 0;
	int       free_run = 0;

	integer_pixel_scaler_top u_dut (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (in_valid),
		.in_stall  (in_stall),
		.opcode    (opcode),
		.red       (red),
		.green     (green),
		.blue      (blue),
		.out_valid (out_valid),
		.out_stall (out_stall),
		.red_out   (red_out),
		.green_out (green_out),
		.blue_out  (blue_out),
		.has_pixel (has_pixel),
		.pad_bytes (pad_bytes),
		.rejected  (rejected),
		.last      (last),
		.cfg_valid (cfg_valid),
		.cfg_ready (cfg_ready),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data)
	);

	// 12 ns clock
	always begin
		#6 clk = 1'b1;
		#6 clk = 1'b0;
	end

	// idle length: mostly none or short, a few long
	function automatic int pick_gap();
		int r;
		r = $urandom_range(0, 99);
		if (r < 55) return 0;
		if (r < 85) return $urandom_range(1, 3);
		if (r < 97) return $urandom_range(4, 12);
		return $urandom_range(20, 60);
	endfunction

	function automatic logic [ips_pkg::CHAN_W-1:0] rnd_byte();
		return ips_pkg::CHAN_W'($urandom_range(0, 255));
	endfunction

	// register values as the block applies them
	function automatic int eff_factor(input logic [ips_pkg::FACTOR_W-1:0] raw);
		if (raw == 0) return 1;
		if (raw > FACTOR_CAP) return FACTOR_CAP;
		return int'(raw);
	endfunction

	function automatic int eff_width(input logic [ips_pkg::WIDTH_W-1:0] raw);
		if (raw == 0) return 1;
		if (raw > WIDTH_CAP) return WIDTH_CAP;
		return int'(raw);
	endfunction

	// zero bytes that bring a row of out_w pixels to a 4-byte multiple
	function automatic logic [ips_pkg::PAD_W-1:0] row_pad(input int out_w);
		return ips_pkg::PAD_W'((4 - ((out_w * 3) & 3)) & 3);
	endfunction

	task automatic push_res(input logic [ips_pkg::PIX_W-1:0] pix, input logic has,
		input logic [ips_pkg::PAD_W-1:0] pad, input logic rej, input logic lst);
		pix_res_t e;
		e.red       = has ? pix[23:16] : '0;
		e.green     = has ? pix[15:8] : '0;
		e.blue      = has ? pix[7:0] : '0;
		e.has_pixel = has;
		e.pad_bytes = pad;
		e.rejected  = rej;
		e.last      = lst;
		owed.push_back(e);
	endtask

	task automatic emit_copies(input logic [ips_pkg::PIX_W-1:0] pix, input int f,
		input logic [ips_pkg::PAD_W-1:0] pad);
		for (int i = 0; i < f; i++)
			push_res(pix, 1'b1, (i == f - 1) ? pad : '0, 1'b0, i == f - 1);
	endtask

	// expected output of one accepted input item
	task automatic scale_step(input logic op, input logic [ips_pkg::PIX_W-1:0] pix);
		int f;
		int w;
		logic row_end;
		logic out_row;
		logic pass;
		logic [ips_pkg::PAD_W-1:0] pad;
		f = eff_factor(reg_factor);
		w = eff_width(reg_width);
		if (op == ips_pkg::OP_PIXEL) begin
			if (rows_owed != 0) begin
				push_res('0, 1'b0, '0, 1'b1, 1'b1);
				return;
			end
			row_end = col_pos >= w - 1;
			if (reg_mode == ips_pkg::MODE_REPLICATE) begin
				pad = row_end ? row_pad(w * f) : '0;
				line_mem[col_pos % LINE_DEPTH] = pix;
				if (row_end) begin
					col_pos   = '0;
					rows_owed = 4'(f - 1);
					rep_pos   = '0;
				end else begin
					col_pos++;
				end
				emit_copies(pix, f, pad);
			end else begin
				out_row = row_ph == 0;
				pass    = out_row && (col_pos % f) == 0;
				pad     = (row_end && out_row) ? row_pad((w + f - 1) / f) : '0;
				if (pass)
					push_res(pix, 1'b1, pad, 1'b0, 1'b1);
				else if (pad != 0)
					push_res('0, 1'b0, pad, 1'b0, 1'b1);
				if (row_end) begin
					col_pos = '0;
					row_ph  = (row_ph + 1 >= f) ? 4'd0 : 4'(row_ph + 4'd1);
				end else begin
					col_pos++;
				end
			end
		end else if (reg_mode != ips_pkg::MODE_REPLICATE || rows_owed == 0) begin
			push_res('0, 1'b0, '0, 1'b1, 1'b1);
		end else begin
			row_end = rep_pos >= w - 1;
			pad = row_end ? row_pad(w * f) : '0;
			pix = line_mem[rep_pos % LINE_DEPTH];
			if (row_end) begin
				rep_pos = '0;
				rows_owed--;
			end else begin
				rep_pos++;
			end
			emit_copies(pix, f, pad);
		end
	endtask

	function automatic void check_field(input string name, input logic [7:0] want,
		input logic [7:0] got);
		if (got !== want) begin
			$error("%s: expected %0h, got %0h", name, want, got);
			errors++;
		end
	endfunction

	// output checker: every transfer against the oldest expectation
	always @(posedge clk) begin : out_check
		pix_res_t want;
		if (arst_n && out_valid && !out_stall) begin
			if (owed.size() == 0) begin
				$error("output transfer with nothing expected");
				errors++;
			end else begin
				want = owed.pop_front();
				check_field("red_out", want.red, red_out);
				check_field("green_out", want.green, green_out);
				check_field("blue_out", want.blue, blue_out);
				check_field("has_pixel", 8'(want.has_pixel), 8'(has_pixel));
				check_field("pad_bytes", 8'(want.pad_bytes), 8'(pad_bytes));
				check_field("rejected", 8'(want.rejected), 8'(rejected));
				check_field("last", 8'(want.last), 8'(last));
			end
		end
	end

	// receiver stall pattern, with a counted long hold on request
	always @(negedge clk) begin : stall_gen
		logic nxt;
		if (hold_req) begin
			hold_req = 1'b0;
			hold_cnt = HOLD_CYC;
		end
		if (hold_cnt > 0) begin
			hold_cnt--;
			nxt = 1'b1;
		end else if (calm) begin
			nxt = 1'b0;
		end else if (stall_run > 0) begin
			stall_run--;
			nxt = 1'b1;
		end else if (free_run > 0) begin
			free_run--;
			nxt = 1'b0;
		end else begin
			stall_run = pick_gap();
			free_run  = ($urandom_range(0, 19) == 0) ? 80 : $urandom_range(0, 12);
			nxt = stall_run > 0;
			if (stall_run > 0)
				stall_run--;
		end
		out_stall <= nxt;
	end

	// one input transfer; valid stays high for a following item
	task automatic send_item(input logic op, input logic [ips_pkg::CHAN_W-1:0] r,
		input logic [ips_pkg::CHAN_W-1:0] g, input logic [ips_pkg::CHAN_W-1:0] b);
		int gap;
		gap = calm ? 0 : pick_gap();
		@(negedge clk);
		if (gap > 0) begin
			in_valid <= 1'b0;
			repeat (gap) @(negedge clk);
		end
		in_valid <= 1'b1;
		opcode   <= op;
		red      <= r;
		green    <= g;
		blue     <= b;
		do @(posedge clk); while (in_stall);
		scale_step(op, {r, g, b});
	endtask

	task automatic send_rand(input logic op);
		send_item(op, rnd_byte(), rnd_byte(), rnd_byte());
	endtask

	task automatic drop_valid();
		if (in_valid) begin
			@(negedge clk);
			in_valid <= 1'b0;
		end
	endtask

	// sender pauses until every expected transfer has come
	task automatic drain();
		drop_valid();
		while (owed.size() != 0) @(posedge clk);
	endtask

	task automatic settle();
		drain();
		repeat (SETTLE_CYC) @(posedge clk);
	endtask

	task automatic write_reg(input logic [ips_pkg::CFG_IDX_W-1:0] idx,
		input logic [ips_pkg::CFG_DATA_W-1:0] data);
		settle();
		@(negedge clk);
		cfg_valid <= 1'b1;
		cfg_index <= idx;
		cfg_data  <= data;
		do @(posedge clk); while (!cfg_ready);
		case (idx)
			ips_pkg::CFG_MODE:   reg_mode   = data[0];
			ips_pkg::CFG_FACTOR: reg_factor = data[ips_pkg::FACTOR_W-1:0];
			ips_pkg::CFG_WIDTH:  reg_width  = data[ips_pkg::WIDTH_W-1:0];
			default: ;
		endcase
		@(negedge clk);
		cfg_valid <= 1'b0;
	endtask

	// complete the open row and owed replays so a new setting starts clean
	task automatic finish_rows();
		while (1) begin
			while (rows_owed != 0 && reg_mode == ips_pkg::MODE_REPLICATE)
				send_rand(ips_pkg::OP_REPLAY);
			if (col_pos == 0 || rows_owed != 0)
				break;
			send_rand(ips_pkg::OP_PIXEL);
		end
	endtask

	// unused upper data bits are set at random
	task automatic new_setting(input logic mode, input logic [ips_pkg::FACTOR_W-1:0] fac,
		input logic [ips_pkg::WIDTH_W-1:0] wid);
		logic [ips_pkg::CFG_DATA_W-1:0] junk;
		finish_rows();
		junk = $urandom_range(0, 1) ? ips_pkg::CFG_DATA_W'($urandom) : '0;
		write_reg(ips_pkg::CFG_MODE, {junk[ips_pkg::CFG_DATA_W-1:1], mode});
		junk = $urandom_range(0, 1) ? ips_pkg::CFG_DATA_W'($urandom) : '0;
		write_reg(ips_pkg::CFG_FACTOR, {junk[ips_pkg::CFG_DATA_W-1:ips_pkg::FACTOR_W], fac});
		write_reg(ips_pkg::CFG_WIDTH, ips_pkg::CFG_DATA_W'(wid));
	endtask

	// reset values: factor 1, width 1
	task automatic test_defaults();
		send_rand(ips_pkg::OP_REPLAY);
		send_item(ips_pkg::OP_PIXEL, 8'h00, 8'h00, 8'h00);
		send_item(ips_pkg::OP_PIXEL, 8'hFF, 8'hFF, 8'hFF);
		send_rand(ips_pkg::OP_PIXEL);
	endtask

	task automatic test_replicate();
		new_setting(ips_pkg::MODE_REPLICATE, 5'd3, 11'd2);
		send_item(ips_pkg::OP_PIXEL, 8'hFF, 8'h00, 8'h00);
		send_item(ips_pkg::OP_PIXEL, 8'h00, 8'hFF, 8'h00);
		// pixel while replays are owed
		send_rand(ips_pkg::OP_PIXEL);
		repeat (4) send_rand(ips_pkg::OP_REPLAY);
		// replay with none owed
		send_rand(ips_pkg::OP_REPLAY);
	endtask

	// owed replays survive a switch to decimate mode and are refused there
	task automatic test_owed_in_decimate();
		new_setting(ips_pkg::MODE_REPLICATE, 5'd2, 11'd2);
		repeat (2) send_rand(ips_pkg::OP_PIXEL);
		write_reg(ips_pkg::CFG_MODE, ips_pkg::CFG_DATA_W'(ips_pkg::MODE_DECIMATE));
		send_rand(ips_pkg::OP_PIXEL);
		send_rand(ips_pkg::OP_REPLAY);
		write_reg(ips_pkg::CFG_MODE, ips_pkg::CFG_DATA_W'(ips_pkg::MODE_REPLICATE));
		repeat (2) send_rand(ips_pkg::OP_REPLAY);
	endtask

	// passed, dropped and padding-only pixels
	task automatic test_decimate();
		new_setting(ips_pkg::MODE_DECIMATE, 5'd2, 11'd4);
		repeat (8) send_rand(ips_pkg::OP_PIXEL);
	endtask

	// counters left past a width or factor that shrank
	task automatic test_shrunk_counters();
		new_setting(ips_pkg::MODE_DECIMATE, 5'd4, 11'd2);
		repeat (6) send_rand(ips_pkg::OP_PIXEL);
		write_reg(ips_pkg::CFG_FACTOR, 11'd2);
		repeat (2) send_rand(ips_pkg::OP_PIXEL);
		write_reg(ips_pkg::CFG_WIDTH, 11'h7FF);
		repeat (4) send_rand(ips_pkg::OP_PIXEL);
		write_reg(ips_pkg::CFG_WIDTH, 11'd2);
		send_rand(ips_pkg::OP_PIXEL);
		new_setting(ips_pkg::MODE_REPLICATE, 5'd2, 11'd4);
		repeat (4) send_rand(ips_pkg::OP_PIXEL);
		repeat (3) send_rand(ips_pkg::OP_REPLAY);
		write_reg(ips_pkg::CFG_WIDTH, 11'd2);
		send_rand(ips_pkg::OP_REPLAY);
	endtask

	// zero and oversized register values, spare index
	task automatic test_reg_extremes();
		new_setting(ips_pkg::MODE_REPLICATE, 5'd31, 11'd1);
		send_rand(ips_pkg::OP_PIXEL);
		repeat (15) send_rand(ips_pkg::OP_REPLAY);
		new_setting(ips_pkg::MODE_REPLICATE, 5'd0, 11'd0);
		send_rand(ips_pkg::OP_PIXEL);
		new_setting(ips_pkg::MODE_DECIMATE, 5'd17, 11'd3);
		repeat (3) send_rand(ips_pkg::OP_PIXEL);
		write_reg(CFG_SPARE, 11'h7FF);
		send_rand(ips_pkg::OP_PIXEL);
	endtask

	// long receiver hold while the sender keeps offering
	task automatic test_backpressure();
		new_setting(ips_pkg::MODE_REPLICATE, 5'd4, 11'd4);
		calm = 1'b1;
		hold_req = 1'b1;
		repeat (4) send_rand(ips_pkg::OP_PIXEL);
		repeat (12) send_rand(ips_pkg::OP_REPLAY);
		calm = 1'b0;
		drain();
	endtask

	task automatic test_random_stream();
		logic mode;
		logic [ips_pkg::FACTOR_W-1:0] fac;
		logic [ips_pkg::WIDTH_W-1:0] wid;
		logic op;
		for (int ph = 0; ph < PHASES; ph++) begin
			mode = 1'($urandom_range(0, 1));
			if ($urandom_range(0, 9) == 0) begin
				case ($urandom_range(0, 3))
					0: fac = 5'd0;
					1: fac = 5'd16;
					2: fac = 5'd17;
					default: fac = 5'd31;
				endcase
			end else begin
				fac = 5'($urandom_range(1, 4));
			end
			wid = ($urandom_range(0, 11) == 0) ? 11'd0 : 11'($urandom_range(1, 9));
			if (mode == ips_pkg::MODE_REPLICATE && eff_factor(fac) == FACTOR_CAP && wid > 3)
				wid = 11'd3;
			new_setting(mode, fac, wid);
			calm = ph == 3;
			for (int n = 0; n < PHASE_LEN; n++) begin
				if (n == 20)
					drain();
				// mostly well-formed rows and replays, some refused items
				if (reg_mode == ips_pkg::MODE_REPLICATE && rows_owed != 0)
					op = ($urandom_range(0, 9) == 0) ? ips_pkg::OP_PIXEL : ips_pkg::OP_REPLAY;
				else
					op = ($urandom_range(0, 9) == 0) ? ips_pkg::OP_REPLAY : ips_pkg::OP_PIXEL;
				send_rand(op);
			end
			calm = 1'b0;
		end
	endtask

	// main sequence
	initial begin
		reg_mode   = ips_pkg::MODE_REPLICATE;
		reg_factor = 5'd1;
		reg_width  = 11'd1;
		col_pos    = '0;
		row_ph     = '0;
		rows_owed  = '0;
		rep_pos    = '0;
		repeat (6) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;
		test_defaults();
		test_replicate();
		test_owed_in_decimate();
		test_decimate();
		test_shrunk_counters();
		test_reg_extremes();
		test_backpressure();
		test_random_stream();
		drain();
		repeat (2 * SETTLE_CYC) @(posedge clk);
		if (errors == 0)
			$display("tb_integer_pixel_scaler_top: clean");
		else
			$display("tb_integer_pixel_scaler_top: errors");
		$finish;
	end

	// run limit
	initial begin
		#(20_000_000);
		$display("tb_integer_pixel_scaler_top: errors");
		$finish;
	end

endmodule
